// ===== hdl/cbm_pkg.sv =====
// Shared types, constants and control program for the cell balance monitor.
package cbm_pkg;

  localparam int unsigned SampleW   = 10;
  localparam int unsigned MvW       = 16;
  localparam int unsigned DutyW     = 8;
  localparam int unsigned ProdW     = SampleW + MvW;
  localparam int unsigned DivSteps  = ProdW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);
  localparam int unsigned PcW       = 4;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;

  localparam logic [SampleW-1:0] RefCountRst = 10'd1023;
  localparam logic [MvW-1:0]     FullMvRst   = 16'd4200;
  localparam logic [MvW-1:0]     MaxMvRst    = 16'd4250;
  localparam logic [SampleW-1:0] HystRst     = 10'd20;
  localparam logic [DutyW-1:0]   DutyTopRst  = 8'd165;

  localparam logic [7:0] ChStart  = 8'h3E;  // '>'
  localparam logic [7:0] ChDash   = 8'h2D;  // '-'
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChFull   = 8'h4F;  // 'O'
  localparam logic [7:0] ChMax    = 8'h51;  // 'Q'
  localparam logic [7:0] ChCharge = 8'h43;  // 'C'

  typedef enum logic [2:0] {
    REG_REF_COUNT = 3'd0,
    REG_FULL_MV   = 3'd1,
    REG_MAX_MV    = 3'd2,
    REG_HYST      = 3'd3,
    REG_DUTY_TOP  = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_OVERFULL = 2'd1,
    ST_OVERMAX  = 2'd2,
    ST_CHARGING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_IDLE = 3'd0,
    OP_MUL  = 3'd1,
    OP_DIV  = 3'd2,
    OP_UPD  = 3'd3,
    OP_EMIT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_IN   = 2'd1,
    HOLD_DIV  = 2'd2,
    HOLD_OUT  = 2'd3
  } hold_e;

  typedef enum logic [2:0] {
    BS_START  = 3'd0,
    BS_STATUS = 3'd1,
    BS_DASH   = 3'd2,
    BS_MV_HI  = 3'd3,
    BS_MV_LO  = 3'd4,
    BS_DUTY   = 3'd5,
    BS_CR     = 3'd6,
    BS_NUL    = 3'd7
  } bsel_e;

  typedef struct packed {
    op_e            op;
    hold_e          hold;
    bsel_e          sel;
    logic           last;
    logic [PcW-1:0] next;
  } uword_t;

  typedef struct packed {
    op_e   op;
    logic  take;
    bsel_e sel;
  } ctrl_t;

  typedef struct packed {
    logic [SampleW-1:0] ref_count;
    logic [MvW-1:0]     full_mv;
    logic [MvW-1:0]     max_mv;
    logic [SampleW-1:0] hyst;
    logic [DutyW-1:0]   duty_top;
  } cfg_t;

  // Control program: each step holds on its condition, else moves to next.
  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{op: OP_IDLE, hold: HOLD_IN, sel: BS_START, last: 1'b0, next: 4'd1};
    case (pc)
      4'd0:  w = '{op: OP_IDLE, hold: HOLD_IN,   sel: BS_START,  last: 1'b0, next: 4'd1};
      4'd1:  w = '{op: OP_MUL,  hold: HOLD_NONE, sel: BS_START,  last: 1'b0, next: 4'd2};
      4'd2:  w = '{op: OP_DIV,  hold: HOLD_DIV,  sel: BS_START,  last: 1'b0, next: 4'd3};
      4'd3:  w = '{op: OP_UPD,  hold: HOLD_NONE, sel: BS_START,  last: 1'b0, next: 4'd4};
      4'd4:  w = '{op: OP_EMIT, hold: HOLD_OUT,  sel: BS_START,  last: 1'b0, next: 4'd5};
      4'd5:  w = '{op: OP_EMIT, hold: HOLD_OUT,  sel: BS_STATUS, last: 1'b0, next: 4'd6};
      4'd6:  w = '{op: OP_EMIT, hold: HOLD_OUT,  sel: BS_DASH,   last: 1'b0, next: 4'd7};
      4'd7:  w = '{op: OP_EMIT, hold: HOLD_OUT,  sel: BS_MV_HI,  last: 1'b0, next: 4'd8};
      4'd8:  w = '{op: OP_EMIT, hold: HOLD_OUT,  sel: BS_MV_LO,  last: 1'b0, next: 4'd9};
      4'd9:  w = '{op: OP_EMIT, hold: HOLD_OUT,  sel: BS_DUTY,   last: 1'b0, next: 4'd10};
      4'd10: w = '{op: OP_EMIT, hold: HOLD_OUT,  sel: BS_CR,     last: 1'b0, next: 4'd11};
      4'd11: w = '{op: OP_EMIT, hold: HOLD_OUT,  sel: BS_NUL,    last: 1'b1, next: 4'd0};
      default: w = '{op: OP_IDLE, hold: HOLD_NONE, sel: BS_START, last: 1'b0, next: 4'd0};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] status_char(input status_e st);
    logic [7:0] c;
    unique case (st)
      ST_OVERFULL: c = ChFull;
      ST_OVERMAX:  c = ChMax;
      ST_CHARGING: c = ChCharge;
      default:     c = ChNul;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/cbm_datapath.sv =====
// Multiply, serial divide, status and duty update, and frame byte select.
module cbm_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cbm_pkg::ctrl_t               ctrl_i,
  input  cbm_pkg::cfg_t                cfg_i,
  input  logic [cbm_pkg::SampleW-1:0]  sample_i,
  output logic                         div_busy_o,
  output logic [7:0]                   tx_byte_o
);

  logic [cbm_pkg::SampleW-1:0] sample_q;
  logic [cbm_pkg::ProdW-1:0]   quot_q, quot_d;
  logic [cbm_pkg::SampleW-1:0] rem_q, rem_d;
  logic [cbm_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [cbm_pkg::MvW-1:0]     mv_q, mv_d;
  cbm_pkg::status_e            status_q, status_d;
  logic [cbm_pkg::DutyW-1:0]   duty_q, duty_d;

  logic [cbm_pkg::ProdW-1:0]   prod;
  logic [cbm_pkg::SampleW:0]   trial;
  logic [cbm_pkg::SampleW:0]   diff;
  logic                        ge;
  logic                        over_ref;
  logic                        over_max;
  logic                        in_band;

  assign prod  = {{cbm_pkg::MvW{1'b0}}, sample_q} *
                 {{cbm_pkg::SampleW{1'b0}}, cfg_i.full_mv};
  // Restoring divide step; a zero divisor yields all ones, which saturates.
  assign trial = {rem_q, quot_q[cbm_pkg::ProdW-1]};
  assign ge    = trial >= {1'b0, cfg_i.ref_count};
  assign diff  = trial - {1'b0, cfg_i.ref_count};

  assign over_ref = sample_q > cfg_i.ref_count;
  assign over_max = mv_d > cfg_i.max_mv;
  assign in_band  = ({1'b0, sample_q} + {1'b0, cfg_i.hyst}) >= {1'b0, cfg_i.ref_count};

  always_comb begin
    quot_d   = quot_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    duty_d   = duty_q;
    mv_d     = (|quot_q[cbm_pkg::ProdW-1:cbm_pkg::MvW]) ? {cbm_pkg::MvW{1'b1}}
                                                         : quot_q[cbm_pkg::MvW-1:0];
    case (ctrl_i.op)
      cbm_pkg::OP_MUL: begin
        quot_d = prod;
        rem_d  = '0;
        cnt_d  = cbm_pkg::DivCntW'(cbm_pkg::DivSteps - 1);
      end
      cbm_pkg::OP_DIV: begin
        quot_d = {quot_q[cbm_pkg::ProdW-2:0], ge};
        rem_d  = ge ? diff[cbm_pkg::SampleW-1:0] : trial[cbm_pkg::SampleW-1:0];
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      cbm_pkg::OP_UPD: begin
        if (over_ref) begin
          status_d = over_max ? cbm_pkg::ST_OVERMAX : cbm_pkg::ST_OVERFULL;
          if (duty_q < cfg_i.duty_top) begin
            duty_d = duty_q + 1'b1;
          end
        end else begin
          // Keep over-full inside the hysteresis band unless over maximum
          status_d = (status_q == cbm_pkg::ST_OVERFULL && !over_max && in_band) ?
                     cbm_pkg::ST_OVERFULL : cbm_pkg::ST_CHARGING;
          if (duty_q != '0) begin
            duty_d = duty_q - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      status_q <= cbm_pkg::ST_NONE;
      duty_q   <= '0;
    end else begin
      cnt_q    <= cnt_d;
      status_q <= status_d;
      duty_q   <= duty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      sample_q <= sample_i;
    end
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (ctrl_i.op == cbm_pkg::OP_UPD) begin
      mv_q <= mv_d;
    end
  end

  assign div_busy_o = cnt_q != '0;

  always_comb begin
    unique case (ctrl_i.sel)
      cbm_pkg::BS_START:  tx_byte_o = cbm_pkg::ChStart;
      cbm_pkg::BS_STATUS: tx_byte_o = cbm_pkg::status_char(status_q);
      cbm_pkg::BS_DASH:   tx_byte_o = cbm_pkg::ChDash;
      cbm_pkg::BS_MV_HI:  tx_byte_o = mv_q[15:8];
      cbm_pkg::BS_MV_LO:  tx_byte_o = mv_q[7:0];
      cbm_pkg::BS_DUTY:   tx_byte_o = duty_q;
      cbm_pkg::BS_CR:     tx_byte_o = cbm_pkg::ChCr;
      default:            tx_byte_o = cbm_pkg::ChNul;
    endcase
  end

endmodule

// ===== hdl/cell_balance_monitor_top.sv =====
// Top level of the cell balance monitor: register port, sequencer, output stage.
//
// Usage:
//   s_axis carries one 10-bit ADC cell sample per transaction. For each sample
//   the block reports an 8-byte frame on m_axis, one byte per transaction:
//   '>', status char, '-', mV high, mV low, bypass duty, CR, NUL; tlast marks
//   the NUL byte. The APB port holds five calibration/limit registers at byte
//   addresses 0,4,8,12,16; write them only while the block is idle.
// Timing:
//   A short control program steps a 10x16 multiply, a 26-step restoring divide
//   (one quotient bit per cycle), a status/duty update and eight byte loads.
//   The first frame byte is loaded into the output register after the divide
//   and the update; the next sample is taken only once the NUL byte has been
//   loaded, so the block does not take a new sample while one is in work.
// Reset:
//   Registers return to their calibration defaults, status to none and duty to
//   zero; no frame is pending.
// Backpressure:
//   The output register holds a byte until it is taken; the sequencer waits
//   on each byte load, so a stalled receiver stretches the frame without loss.
module cell_balance_monitor_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,   // [9:0] adc_sample
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // [7:0] tx_byte
  output logic                       m_axis_tlast,   // last_byte
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cbm_pkg::AddrW-1:0]  paddr,
  input  logic [cbm_pkg::DataW-1:0]  pwdata,
  output logic [cbm_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  cbm_pkg::cfg_t              cfg_q;
  logic [cbm_pkg::PcW-1:0]    pc_q, pc_d;
  cbm_pkg::uword_t            uw;
  cbm_pkg::ctrl_t             ctrl;
  logic                       in_hs;
  logic                       out_free;
  logic                       hold;
  logic                       load_out;
  logic                       div_busy;
  logic [7:0]                 tx_byte;
  logic                       out_valid_q;
  logic [7:0]                 out_data_q;
  logic                       out_last_q;
  logic                       wr_en;
  cbm_pkg::reg_e              reg_sel;

  // Register port
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = cbm_pkg::reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_count <= cbm_pkg::RefCountRst;
      cfg_q.full_mv   <= cbm_pkg::FullMvRst;
      cfg_q.max_mv    <= cbm_pkg::MaxMvRst;
      cfg_q.hyst      <= cbm_pkg::HystRst;
      cfg_q.duty_top  <= cbm_pkg::DutyTopRst;
    end else if (wr_en) begin
      unique case (reg_sel)
        cbm_pkg::REG_REF_COUNT: cfg_q.ref_count <= pwdata[cbm_pkg::SampleW-1:0];
        cbm_pkg::REG_FULL_MV:   cfg_q.full_mv   <= pwdata[cbm_pkg::MvW-1:0];
        cbm_pkg::REG_MAX_MV:    cfg_q.max_mv    <= pwdata[cbm_pkg::MvW-1:0];
        cbm_pkg::REG_HYST:      cfg_q.hyst      <= pwdata[cbm_pkg::SampleW-1:0];
        cbm_pkg::REG_DUTY_TOP:  cfg_q.duty_top  <= pwdata[cbm_pkg::DutyW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      cbm_pkg::REG_REF_COUNT: prdata = cbm_pkg::DataW'(cfg_q.ref_count);
      cbm_pkg::REG_FULL_MV:   prdata = cbm_pkg::DataW'(cfg_q.full_mv);
      cbm_pkg::REG_MAX_MV:    prdata = cbm_pkg::DataW'(cfg_q.max_mv);
      cbm_pkg::REG_HYST:      prdata = cbm_pkg::DataW'(cfg_q.hyst);
      cbm_pkg::REG_DUTY_TOP:  prdata = cbm_pkg::DataW'(cfg_q.duty_top);
      default:                prdata = '0;
    endcase
  end

  // Sequencer
  assign uw            = cbm_pkg::ucode(pc_q);
  assign s_axis_tready = uw.op == cbm_pkg::OP_IDLE;
  assign in_hs         = s_axis_tvalid & s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign load_out      = (uw.op == cbm_pkg::OP_EMIT) && out_free;

  always_comb begin
    case (uw.hold)
      cbm_pkg::HOLD_IN:  hold = !in_hs;
      cbm_pkg::HOLD_DIV: hold = div_busy;
      cbm_pkg::HOLD_OUT: hold = !out_free;
      default:           hold = 1'b0;
    endcase
    pc_d = hold ? pc_q : uw.next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl.op   = uw.op;
  assign ctrl.take = in_hs;
  assign ctrl.sel  = uw.sel;

  cbm_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg_q),
    .sample_i   (s_axis_tdata[cbm_pkg::SampleW-1:0]),
    .div_busy_o (div_busy),
    .tx_byte_o  (tx_byte)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= tx_byte;
      out_last_q <= uw.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== hdl/cbm_checker.sv =====
// Port-level checks for the cell balance monitor, bound to the top level.
module cbm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [7:0]                 m_axis_tdata,
  input logic                       m_axis_tlast,
  input logic                       pready
);

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output transaction changed");

  // One sample at a time: no back-to-back input transactions
  a_in_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a sample is in work");

  // Frame ends on the NUL byte
  a_last_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'h00)
    else $error("frame end byte is not NUL");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("register port stalled");

endmodule

bind cell_balance_monitor_top cbm_checker u_cbm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);
